// ===== rtl/utf8_emoji_scan_top_assert.svh =====
// assertion macros for the utf8 emoji scanner
// uses the clk and arst_n names of the module that includes it
`ifndef UTF8_EMOJI_SCAN_TOP_ASSERT_SVH
`define UTF8_EMOJI_SCAN_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define U8ES_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define U8ES_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define U8ES_ASSERT_IMP(lbl, ante, cons)
`define U8ES_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/u8es_pkg.sv =====
// shared types and constants for the utf8 emoji scanner
// no dependencies
`default_nettype none
package u8es_pkg;

	localparam int COUNT_BITS = 16;
	localparam int CMP_W      = (COUNT_BITS > 16) ? COUNT_BITS : 16;
	localparam int CP_W       = 21;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [7:0] SPACE_CHAR   = 8'h20;
	localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

	typedef enum logic [3:0] {
		CAT_SMILEY    = 4'd0,
		CAT_MISC      = 4'd1,
		CAT_TRANSPORT = 4'd2,
		CAT_HEART     = 4'd3,
		CAT_GESTURE   = 4'd4,
		CAT_PEOPLE    = 4'd5,
		CAT_ANIMAL    = 4'd6,
		CAT_FOOD      = 4'd7,
		CAT_MUSIC     = 4'd8,
		CAT_SYMBOL    = 4'd9,
		CAT_OTHER     = 4'd10
	} cat_t;

	typedef struct packed {
		logic is_emoji;
		cat_t category;
	} cls_t;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		logic [COUNT_BITS-1:0] r;
		r = (v == COUNT_MAX) ? v : v + 1'b1;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/u8es_classify.sv =====
// emoji flag and first-match category of one code point
// depends on u8es_pkg
`default_nettype none
module u8es_classify import u8es_pkg::*; (
	input  wire logic [CP_W-1:0] cp,
	output cls_t                 cls
);

	function automatic logic in_rng(input logic [CP_W-1:0] v, input logic [CP_W-1:0] lo,
			input logic [CP_W-1:0] hi);
		return (v >= lo) && (v <= hi);
	endfunction

	logic r_smiley, r_misc, r_transport;

	always_comb begin
		r_smiley    = in_rng(cp, 21'h1F600, 21'h1F64F);
		r_misc      = in_rng(cp, 21'h1F300, 21'h1F5FF);
		r_transport = in_rng(cp, 21'h1F680, 21'h1F6FF);

		cls.is_emoji = r_smiley || r_misc || r_transport
			|| in_rng(cp, 21'h02600, 21'h027BF)
			|| in_rng(cp, 21'h1F900, 21'h1F9FF)
			|| in_rng(cp, 21'h1FA00, 21'h1FAFF)
			|| (cp == 21'h0200D);

		// first match wins, the two people spans overlap and cover 1f440-1f4f7
		if (r_smiley) begin
			cls.category = CAT_SMILEY;
		end else if (r_misc) begin
			cls.category = CAT_MISC;
		end else if (r_transport) begin
			cls.category = CAT_TRANSPORT;
		end else if (cp == 21'h02764) begin
			cls.category = CAT_HEART;
		end else if (in_rng(cp, 21'h0270A, 21'h0270C)) begin
			cls.category = CAT_GESTURE;
		end else if (in_rng(cp, 21'h1F440, 21'h1F4A9) || in_rng(cp, 21'h1F44B, 21'h1F4F7)) begin
			cls.category = CAT_PEOPLE;
		end else if (in_rng(cp, 21'h1F400, 21'h1F43F)) begin
			cls.category = CAT_ANIMAL;
		end else if (in_rng(cp, 21'h1F32D, 21'h1F37F)) begin
			cls.category = CAT_FOOD;
		end else if (in_rng(cp, 21'h1F3B5, 21'h1F3BC)) begin
			cls.category = CAT_MUSIC;
		end else if (in_rng(cp, 21'h02694, 21'h026F9)) begin
			cls.category = CAT_SYMBOL;
		end else begin
			cls.category = CAT_OTHER;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/utf8_emoji_scan_top.sv =====
// utf8 emoji scanner top level: byte input stage, decode state, result register
// depends on u8es_pkg, u8es_classify and utf8_emoji_scan_top_assert.svh
//
// usage
//  - input stream: one message byte per word on s_axis_tdata, s_axis_tlast on the
//    final byte of a message
//  - output stream: one word per completed character, plus one word for the final
//    byte even when no character completes there (m_axis_tuser low then)
//  - bytes that only extend a character give no output word
//  - a byte passes the input register, then decode, classify and counter update into
//    the output register; a stalled output word can hold it in the input register
//  - throughput: one byte per cycle unless a byte with an output word waits on a
//    stalled receiver, set by the decode and counter update loop
//  - the receiver may stall at will; the output word holds and the input stage
//    keeps taking bytes as long as they produce no output word
//  - cfg_we/cfg_wdata write the non-emoji limit; write it only while idle
//  - reset clears decode state, both counters, the limit and all valid flags
//  - a character cut off by the end of a message is dropped
`default_nettype none
`include "utf8_emoji_scan_top_assert.svh"
module utf8_emoji_scan_top import u8es_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,     // max_non_emoji
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  wire logic        s_axis_tlast,  // last_byte
	// output stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [20:0] code_point, [21] is_emoji, [25:22] category, [26] emoji_only,
	// [42:27] emoji_count, [47:43] zero
	output logic [47:0]      m_axis_tdata,
	output logic             m_axis_tuser,  // char_valid
	output logic             m_axis_tlast   // message_end
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// decode and counting state
	logic [1:0]            bytes_left_q;
	logic [CP_W-1:0]       partial_q;
	logic [COUNT_BITS-1:0] emoji_cnt_q;
	logic [COUNT_BITS-1:0] non_emoji_cnt_q;
	logic [15:0]           max_non_emoji_q;

	// output register
	logic            valid_s2;
	logic            char_valid_s2;
	logic [CP_W-1:0] cp_s2;
	cls_t            cls_s2;
	logic            end_s2;
	logic            only_s2;
	logic [15:0]     count_s2;

	// decode
	logic                  done;
	logic [CP_W-1:0]       cp;
	logic [CP_W-1:0]       shifted;
	logic [1:0]            bytes_left_d;
	logic [CP_W-1:0]       partial_d;
	logic [COUNT_BITS-1:0] emoji_cnt_d;
	logic [COUNT_BITS-1:0] non_emoji_cnt_d;
	logic                  has_res;
	logic                  adv;
	logic                  only_d;
	logic [CMP_W-1:0]      emoji_ext;
	cls_t                  cls;

	u8es_classify u_cls (
		.cp  (cp),
		.cls (cls)
	);

	always_comb begin
		shifted      = {partial_q[CP_W-7:0], byte_s1[5:0]};
		done         = 1'b0;
		cp           = '0;
		bytes_left_d = bytes_left_q;
		partial_d    = partial_q;
		if (bytes_left_q == 2'd0) begin
			// lead byte sets the length; stray continuations act as two-byte leads
			if (!byte_s1[7]) begin
				done = 1'b1;
				cp   = CP_W'(byte_s1);
			end else if (byte_s1 < 8'hE0) begin
				partial_d    = CP_W'(byte_s1[4:0]);
				bytes_left_d = 2'd1;
			end else if (byte_s1 < 8'hF0) begin
				partial_d    = CP_W'(byte_s1[3:0]);
				bytes_left_d = 2'd2;
			end else begin
				partial_d    = CP_W'(byte_s1[2:0]);
				bytes_left_d = 2'd3;
			end
		end else begin
			partial_d    = shifted;
			bytes_left_d = bytes_left_q - 2'd1;
			if (bytes_left_q == 2'd1) begin
				done = 1'b1;
				cp   = shifted;
			end
		end

		emoji_cnt_d     = emoji_cnt_q;
		non_emoji_cnt_d = non_emoji_cnt_q;
		if (done) begin
			partial_d = '0;
			if (cls.is_emoji) begin
				emoji_cnt_d = sat_inc(emoji_cnt_q);
			end else if (cp != CP_W'(SPACE_CHAR) && cp != CP_W'(NEWLINE_CHAR)) begin
				non_emoji_cnt_d = sat_inc(non_emoji_cnt_q);
			end
		end

		// verdict on the updated counters
		only_d = (emoji_cnt_d != '0)
			&& (CMP_W'(non_emoji_cnt_d) <= CMP_W'(max_non_emoji_q));
		emoji_ext = CMP_W'(emoji_cnt_d);

		has_res = done || last_s1;
		adv     = valid_s1 && (!has_res || !valid_s2 || m_axis_tready);
	end

	assign s_axis_tready = !valid_s1 || adv;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// decode state, counters and limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q    <= 2'd0;
			partial_q       <= '0;
			emoji_cnt_q     <= '0;
			non_emoji_cnt_q <= '0;
			max_non_emoji_q <= '0;
		end else begin
			if (cfg_we) begin
				max_non_emoji_q <= cfg_wdata;
			end
			if (adv) begin
				if (last_s1) begin
					// message done: start clean, drop any cut-off character
					bytes_left_q    <= 2'd0;
					partial_q       <= '0;
					emoji_cnt_q     <= '0;
					non_emoji_cnt_q <= '0;
				end else begin
					bytes_left_q    <= bytes_left_d;
					partial_q       <= partial_d;
					emoji_cnt_q     <= emoji_cnt_d;
					non_emoji_cnt_q <= non_emoji_cnt_d;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv && has_res) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_res) begin
			char_valid_s2 <= done;
			cp_s2         <= cp;
			cls_s2.is_emoji <= done && cls.is_emoji;
			cls_s2.category <= done ? cls.category : CAT_OTHER;
			end_s2        <= last_s1;
			only_s2       <= last_s1 && only_d;
			count_s2      <= last_s1 ? emoji_ext[15:0] : 16'd0;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = char_valid_s2;
	assign m_axis_tlast  = end_s2;
	assign m_axis_tdata  = {5'd0, count_s2, only_s2, cls_s2.category, cls_s2.is_emoji, cp_s2};

	// a word without a character only comes from the final byte
	`U8ES_ASSERT_IMP(a_empty_is_end, m_axis_tvalid && !m_axis_tuser, m_axis_tlast)
	// no emoji flag without a character
	`U8ES_ASSERT_IMP(a_emoji_has_char, m_axis_tvalid && m_axis_tdata[21], m_axis_tuser)
	// verdict only on the final word
	`U8ES_ASSERT_IMP(a_only_at_end, m_axis_tvalid && m_axis_tdata[26], m_axis_tlast)
	// end of message leaves clean state
	`U8ES_ASSERT_NXT(a_clear_after_end, adv && last_s1,
		bytes_left_q == 2'd0 && emoji_cnt_q == '0 && non_emoji_cnt_q == '0)

endmodule
`default_nettype wire
